FILE: hdl/lswc_pkg.sv
// Shared constants and types for the line segment window clipper.
package lswc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int U_FRAC = 15;

    typedef enum logic [1:0] {
        STATUS_INSIDE   = 2'd0,
        STATUS_CLIPPED  = 2'd1,
        STATUS_REJECTED = 2'd2
    } clip_status_t;

    typedef enum logic [1:0] {
        REG_WINDOW_LEFT   = 2'd0,
        REG_WINDOW_BOTTOM = 2'd1,
        REG_WINDOW_WIDTH  = 2'd2,
        REG_WINDOW_HEIGHT = 2'd3
    } reg_index_t;

endpackage

FILE: hdl/lswc_divider.sv
// Pipelined restoring divider: quotient of (num << U_FRAC) / den, floor or ceil.
module lswc_divider #(
    parameter int NUM_WIDTH = 18
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [NUM_WIDTH-1:0] num,
    input  logic [NUM_WIDTH-1:0] den,
    input  logic                 round_up,
    output logic [lswc_pkg::U_FRAC:0] quot
);
    import lswc_pkg::*;

    localparam int STEPS = U_FRAC;
    localparam int RW = NUM_WIDTH + 1;

    // num < den always (num <= den for the entering case, handled by caller)
    logic [RW-1:0]        rem_reg [STEPS+1];
    logic [NUM_WIDTH-1:0] den_reg [STEPS+1];
    logic [STEPS-1:0]     q_reg   [STEPS+1];
    logic                 up_reg  [STEPS+1];

    always_comb begin
        rem_reg[0] = {1'b0, num};
        den_reg[0] = den;
        q_reg[0]   = '0;
        up_reg[0]  = round_up;
    end

    genvar g;
    generate
        for (g = 0; g < STEPS; g++) begin : g_step
            logic [RW-1:0] sh;
            logic          ge;
            assign sh = {rem_reg[g][RW-2:0], 1'b0};
            assign ge = (sh >= {1'b0, den_reg[g]});
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[g+1] <= ge ? sh - {1'b0, den_reg[g]} : sh;
                    q_reg[g+1]   <= {q_reg[g][STEPS-2:0], ge};
                    den_reg[g+1] <= den_reg[g];
                    up_reg[g+1]  <= up_reg[g];
                end
            end
        end
    endgenerate

    // floor quotient stays below 32768 since num < den; ceil may reach 32768
    assign quot = {1'b0, q_reg[STEPS]} + {{STEPS{1'b0}},
                  (up_reg[STEPS] && (rem_reg[STEPS] != '0))};
endmodule

FILE: hdl/line_segment_window_clipper_top.sv
// Top level of the line segment window clipper.
// Path from input beat to result beat: edge terms, classification, quotient pipeline, bound combine, multiply, output.
// Throughput: one segment per cycle when not stalled; the fifteen-step quotient pipeline sets depth.
// The whole pipeline advances only while the output register can take data.
// Reset clears valid bits and window registers to zero; payload is not reset.
module line_segment_window_clipper_top #(
    parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // start_x, start_y, end_x, end_y
    input  logic [4*COORD_WIDTH-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // clip_status, out_start_x, out_start_y, out_end_x, out_end_y, zero fill
    output logic [((2+4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import lswc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 2;            // edge terms
    localparam int UW = U_FRAC + 1;
    localparam int DIVLAT = U_FRAC;
    localparam int DEPTH = DIVLAT + 4;     // total stages before output reg
    localparam int OW = ((2 + 4*CW + 7) / 8) * 8;
    localparam int PW = DW + UW + 1;       // product width

    logic signed [CW-1:0] left_reg, bottom_reg;
    logic [CW-2:0]        width_reg, height_reg;
    logic                 wr_en;
    reg_index_t           widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0; bottom_reg <= '0; width_reg <= '0; height_reg <= '0;
        end else if (wr_en) begin
            unique case (widx)
                REG_WINDOW_LEFT:   left_reg   <= pwdata[CW-1:0];
                REG_WINDOW_BOTTOM: bottom_reg <= pwdata[CW-1:0];
                REG_WINDOW_WIDTH:  width_reg  <= pwdata[CW-2:0];
                REG_WINDOW_HEIGHT: height_reg <= pwdata[CW-2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (widx)
            REG_WINDOW_LEFT:   prdata = 32'(left_reg);
            REG_WINDOW_BOTTOM: prdata = 32'(bottom_reg);
            REG_WINDOW_WIDTH:  prdata = 32'(width_reg);
            REG_WINDOW_HEIGHT: prdata = 32'(height_reg);
            default:           prdata = '0;
        endcase
    end

    // pipeline enable: advance whenever output slot frees
    logic adv;
    logic [DEPTH-1:0] vld_reg;
    logic out_vld_reg;
    logic [OW-1:0] out_data_reg;
    logic [OW-1:0] out_data_next;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
    end

    // stage 1: edge terms
    logic signed [CW-1:0] sx, sy, ex, ey;
    assign sx = s_tdata[CW-1:0];
    assign sy = s_tdata[2*CW-1:CW];
    assign ex = s_tdata[3*CW-1:2*CW];
    assign ey = s_tdata[4*CW-1:3*CW];

    logic signed [DW-1:0] p_reg [4];
    logic signed [DW-1:0] q_reg [4];
    logic signed [CW-1:0] s1x_reg, s1y_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg[0] <= DW'(sx) - DW'(ex);
            q_reg[0] <= DW'(sx) - DW'(left_reg);
            p_reg[1] <= DW'(ex) - DW'(sx);
            q_reg[1] <= DW'(left_reg) + DW'({1'b0, width_reg}) - DW'(sx);
            p_reg[2] <= DW'(sy) - DW'(ey);
            q_reg[2] <= DW'(sy) - DW'(bottom_reg);
            p_reg[3] <= DW'(ey) - DW'(sy);
            q_reg[3] <= DW'(bottom_reg) + DW'({1'b0, height_reg}) - DW'(sy);
            s1x_reg <= sx;
            s1y_reg <= sy;
        end
    end

    // stage 2: per-edge classification, divider operands
    logic [DW-1:0] num_reg [4];
    logic [DW-1:0] den_reg [4];
    logic [3:0]    act_reg, rej_reg, ent_reg, full_reg;
    logic signed [CW-1:0] s2x_reg, s2y_reg;
    logic signed [CW:0]   d2x_reg, d2y_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                logic signed [DW-1:0] n, d;
                logic [DW-1:0] num_v, den_v;
                logic act_v, rej_v, ent_v, full_v;
                n = -q_reg[i];
                d = -p_reg[i];
                num_v  = '0;
                den_v  = DW'(1);
                act_v  = 1'b0;
                rej_v  = 1'b0;
                ent_v  = 1'b0;
                full_v = 1'b0;
                if (p_reg[i] == '0) begin
                    rej_v = q_reg[i] < 0;
                end else if (p_reg[i] < 0) begin
                    ent_v = 1'b1;
                    if (n > 0) begin
                        if (n > d) rej_v = 1'b1;
                        else if (n == d) full_v = 1'b1;
                        else begin
                            act_v = 1'b1;
                            num_v = n;
                            den_v = d;
                        end
                    end
                end else begin
                    if (q_reg[i] < 0) rej_v = 1'b1;
                    else if (q_reg[i] < p_reg[i]) begin
                        act_v = 1'b1;
                        num_v = q_reg[i];
                        den_v = p_reg[i];
                    end
                end
                num_reg[i]  <= num_v;
                den_reg[i]  <= den_v;
                act_reg[i]  <= act_v;
                rej_reg[i]  <= rej_v;
                ent_reg[i]  <= ent_v;
                full_reg[i] <= full_v;
            end
            s2x_reg <= s1x_reg;
            s2y_reg <= s1y_reg;
            d2x_reg <= p_reg[1][CW:0];
            d2y_reg <= p_reg[3][CW:0];
        end
    end

    // stages 3..: four dividers, side data delayed alongside
    logic [UW-1:0] quo [4];
    genvar e;
    generate
        for (e = 0; e < 4; e++) begin : g_div
            lswc_divider #(.NUM_WIDTH(DW)) u_div (
                .aclk    (aclk),
                .en      (adv),
                .num     (num_reg[e]),
                .den     (den_reg[e]),
                .round_up(ent_reg[e]),
                .quot    (quo[e])
            );
        end
    endgenerate

    logic [3:0] dact_reg [DIVLAT], drej_reg [DIVLAT], dent_reg [DIVLAT], dfull_reg [DIVLAT];
    logic signed [CW-1:0] dsx_reg [DIVLAT], dsy_reg [DIVLAT];
    logic signed [CW:0]   ddx_reg [DIVLAT], ddy_reg [DIVLAT];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dact_reg[0] <= act_reg; drej_reg[0] <= rej_reg;
            dent_reg[0] <= ent_reg; dfull_reg[0] <= full_reg;
            dsx_reg[0] <= s2x_reg; dsy_reg[0] <= s2y_reg;
            ddx_reg[0] <= d2x_reg; ddy_reg[0] <= d2y_reg;
            for (int i = 1; i < DIVLAT; i++) begin
                dact_reg[i] <= dact_reg[i-1]; drej_reg[i] <= drej_reg[i-1];
                dent_reg[i] <= dent_reg[i-1]; dfull_reg[i] <= dfull_reg[i-1];
                dsx_reg[i] <= dsx_reg[i-1]; dsy_reg[i] <= dsy_reg[i-1];
                ddx_reg[i] <= ddx_reg[i-1]; ddy_reg[i] <= ddy_reg[i-1];
            end
        end
    end

    // combine u bounds
    logic [UW-1:0] u0_reg, u1_reg;
    logic          rej3_reg;
    logic signed [CW-1:0] s3x_reg, s3y_reg;
    logic signed [CW:0]   d3x_reg, d3y_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            logic [UW-1:0] u0, u1;
            logic          r;
            u0 = '0;
            u1 = UW'(1 << U_FRAC);
            r  = 1'b0;
            for (int i = 0; i < 4; i++) begin
                r = r | drej_reg[DIVLAT-1][i];
                if (dent_reg[DIVLAT-1][i]) begin
                    if (dfull_reg[DIVLAT-1][i]) u0 = UW'(1 << U_FRAC);
                    else if (dact_reg[DIVLAT-1][i] && quo[i] > u0) u0 = quo[i];
                end else if (dact_reg[DIVLAT-1][i] && quo[i] < u1) begin
                    u1 = quo[i];
                end
            end
            // full entering bound may exceed a prior max; keep the max
            for (int i = 0; i < 4; i++)
                if (dent_reg[DIVLAT-1][i] && dfull_reg[DIVLAT-1][i]) u0 = UW'(1 << U_FRAC);
            u0_reg   <= u0;
            u1_reg   <= u1;
            rej3_reg <= r || (u0 > u1);
            s3x_reg  <= dsx_reg[DIVLAT-1]; s3y_reg <= dsy_reg[DIVLAT-1];
            d3x_reg  <= ddx_reg[DIVLAT-1]; d3y_reg <= ddy_reg[DIVLAT-1];
        end
    end

    // multiply u*d
    logic signed [PW-1:0] m_reg [4];
    logic                 rej4_reg, ins4_reg;
    logic signed [CW-1:0] s4x_reg, s4y_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_reg[0] <= $signed({1'b0, u0_reg}) * d3x_reg;
            m_reg[1] <= $signed({1'b0, u0_reg}) * d3y_reg;
            m_reg[2] <= $signed({1'b0, u1_reg}) * d3x_reg;
            m_reg[3] <= $signed({1'b0, u1_reg}) * d3y_reg;
            rej4_reg <= rej3_reg;
            ins4_reg <= (u0_reg == '0) && (u1_reg == UW'(1 << U_FRAC));
            s4x_reg  <= s3x_reg; s4y_reg <= s3y_reg;
        end
    end

    // round, add, saturate, pack
    function automatic logic signed [CW-1:0] finish(input logic signed [CW-1:0] s,
                                                    input logic signed [PW-1:0] m);
        logic signed [PW-1:0] t;
        logic signed [PW:0]   v;
        logic signed [PW:0]   hi, lo;
        t  = (m + PW'(1 << (U_FRAC - 1))) >>> U_FRAC;
        v  = (PW+1)'(t) + (PW+1)'(s);
        hi = (PW+1)'((1 << (CW - 1)) - 1);
        lo = -(PW+1)'(1 << (CW - 1));
        if (v > hi) return hi[CW-1:0];
        if (v < lo) return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (adv) out_vld_reg <= vld_reg[DEPTH-1];
    end

    always_comb begin
        out_data_next = '0;
        if (rej4_reg) begin
            out_data_next[1:0] = STATUS_REJECTED;
        end else begin
            out_data_next[1:0] = ins4_reg ? STATUS_INSIDE : STATUS_CLIPPED;
            out_data_next[2+CW-1:2]        = finish(s4x_reg, m_reg[0]);
            out_data_next[2+2*CW-1:2+CW]   = finish(s4y_reg, m_reg[1]);
            out_data_next[2+3*CW-1:2+2*CW] = finish(s4x_reg, m_reg[2]);
            out_data_next[2+4*CW-1:2+3*CW] = finish(s4y_reg, m_reg[3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) out_data_reg <= out_data_next;
    end
endmodule

FILE: hdl/lswc_checker.sv
// Port-level checks for the line segment window clipper, bound to the top level.
module lswc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [1:0]  m_status,
    input logic        pready
);
    import lswc_pkg::*;

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_status != 2'd3)) else $error("bad status code");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready) else $error("accepting while stalled");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_pready: assert property (@(posedge aclk) pready) else $error("pready low");
endmodule

bind line_segment_window_clipper_top lswc_checker u_lswc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_status(m_tdata[1:0]), .pready(pready)
);

FILE: tb/tb_line_segment_window_clipper_top.sv
// Self-checking testbench for the line segment window clipper: directed cases, then random segments.
`timescale 1ns / 100ps
module tb_line_segment_window_clipper_top;
    import lswc_pkg::*;

    localparam int CW = 16;
    localparam int ODW = ((2 + 4 * CW + 7) / 8) * 8;
    localparam int U_ONE = 32768;
    localparam int LATENCY = 20;
    localparam int N_RANDOM = 800;

    typedef struct packed {
        logic signed [CW-1:0] ey;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] sx;
    } segment_t;

    typedef struct packed {
        logic signed [CW-1:0] ey;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] sx;
        clip_status_t         status;
    } visible_t;

    typedef struct {
        segment_t seg;
        bit       typed;
        visible_t res;
    } seg_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [4*CW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ODW-1:0] m_tdata;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    line_segment_window_clipper_top #(.COORD_WIDTH(CW)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // window copy
    longint win_left, win_bottom, win_width, win_height;
    visible_t visible_q[$];
    int errors = 0;
    bit stim_done = 0;

    function automatic longint round_point(longint s, longint u, longint d);
        longint t, v;
        t = u * d + 16384;
        v = s + (t >>> 15);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic bit edge_clip(longint p, longint q, inout longint u0, inout longint u1);
        longint n, d, r;
        if (p == 0) return q >= 0;
        if (p < 0) begin
            n = -q;
            d = -p;
            if (n <= 0) return 1;
            if (n > d) return 0;
            r = (n * U_ONE + d - 1) / d;
            if (r > u0) u0 = r;
            return 1;
        end
        if (q < 0) return 0;
        if (q >= p) return 1;
        r = (q * U_ONE) / p;
        if (r < u1) u1 = r;
        return 1;
    endfunction

    function automatic visible_t clip_segment(segment_t g);
        visible_t r;
        longint sx, sy, dx, dy, u0, u1;
        bit ok;
        sx = g.sx; sy = g.sy;
        dx = longint'(g.ex) - sx;
        dy = longint'(g.ey) - sy;
        u0 = 0; u1 = U_ONE;
        ok = edge_clip(-dx, sx - win_left, u0, u1);
        ok = ok && edge_clip(dx, win_left + win_width - sx, u0, u1);
        ok = ok && edge_clip(-dy, sy - win_bottom, u0, u1);
        ok = ok && edge_clip(dy, win_bottom + win_height - sy, u0, u1);
        if (ok && u0 > u1) ok = 0;
        r = '0;
        if (!ok) begin
            r.status = STATUS_REJECTED;
            return r;
        end
        r.status = (u0 == 0 && u1 == U_ONE) ? STATUS_INSIDE : STATUS_CLIPPED;
        r.sx = CW'(round_point(sx, u0, dx));
        r.sy = CW'(round_point(sy, u0, dy));
        r.ex = CW'(round_point(sx, u1, dx));
        r.ey = CW'(round_point(sy, u1, dy));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, compare at accepted beat
    initial begin : sink
        visible_t got, want;
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = pick_gap();
            m_tready <= (gap == 0);
            if (gap != 0) begin
                repeat (gap) @(posedge aclk);
                m_tready <= 1'b1;
            end
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = visible_t'(m_tdata[2+4*CW-1:0]);
            if (visible_q.size() == 0) begin
                errors++;
                $display("%0t result beat with nothing pending", $time);
            end else begin
                want = visible_q.pop_front();
                if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                if (got.sx !== want.sx) report_mismatch("start_x", got.sx, want.sx);
                if (got.sy !== want.sy) report_mismatch("start_y", got.sy, want.sy);
                if (got.ex !== want.ex) report_mismatch("end_x", got.ex, want.ex);
                if (got.ey !== want.ey) report_mismatch("end_y", got.ey, want.ey);
            end
        end
    end

    task automatic apb_write(reg_index_t idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 2; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_WINDOW_LEFT:   win_left = longint'($signed(val[CW-1:0]));
            REG_WINDOW_BOTTOM: win_bottom = longint'($signed(val[CW-1:0]));
            REG_WINDOW_WIDTH:  win_width = longint'(val[CW-2:0]);
            default:           win_height = longint'(val[CW-2:0]);
        endcase
    endtask

    task automatic drain();
        while (visible_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_window(logic [31:0] l, logic [31:0] b, logic [31:0] w, logic [31:0] h);
        apb_write(REG_WINDOW_LEFT, l);
        apb_write(REG_WINDOW_BOTTOM, b);
        apb_write(REG_WINDOW_WIDTH, w);
        apb_write(REG_WINDOW_HEIGHT, h);
    endtask

    // hold valid high across back-to-back beats
    task automatic send_segment(segment_t g, visible_t want);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= g;
        visible_q.push_back(want);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'(longint'($urandom_range(0, 400)) - 200 + win_left);
            default: return CW'(longint'($urandom_range(0, 400)) - 200 + win_bottom);
        endcase
    endfunction

    initial begin : source
        seg_row_t rows[$];
        seg_row_t row;
        segment_t g;
        int k, mode;
        win_left = 0; win_bottom = 0; win_width = 0; win_height = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset: zero-size window at origin
        row.typed = 1;
        row.seg = '{sx: 0, sy: 0, ex: 0, ey: 0};
        row.res = '{status: STATUS_INSIDE, sx: 0, sy: 0, ex: 0, ey: 0};
        rows.push_back(row);
        row.seg = '{sx: 16, sy: 16, ex: 16, ey: 16};
        row.res = '{status: STATUS_REJECTED, sx: 0, sy: 0, ex: 0, ey: 0};
        rows.push_back(row);
        foreach (rows[i]) send_segment(rows[i].seg, rows[i].res);
        idle_input();
        drain();

        set_window(32'hFFFF_FC00, 32'hFFFF_FE00, 32'd2048, 32'd1024);
        rows.delete();
        row.typed = 0;
        row.res = '0;
        row.seg = '{sx: -100, sy: 0, ex: 100, ey: 50}; rows.push_back(row);
        row.seg = '{sx: -2000, sy: 0, ex: 2000, ey: 0}; rows.push_back(row);
        row.seg = '{sx: 0, sy: -2000, ex: 0, ey: 2000}; rows.push_back(row);
        row.seg = '{sx: -1024, sy: -512, ex: 1024, ey: 512}; rows.push_back(row);
        row.seg = '{sx: -2000, sy: 900, ex: 2000, ey: 900}; rows.push_back(row);
        row.seg = '{sx: -1100, sy: -600, ex: -1100, ey: 600}; rows.push_back(row);
        row.seg = '{sx: -32768, sy: -32768, ex: 32767, ey: 32767}; rows.push_back(row);
        row.seg = '{sx: 32767, sy: -32768, ex: -32768, ey: 32767}; rows.push_back(row);
        row.seg = '{sx: -1100, sy: 0, ex: 0, ey: -600}; rows.push_back(row);
        row.seg = '{sx: -1024, sy: -512, ex: -1024, ey: -512}; rows.push_back(row);
        row.seg = '{sx: 1100, sy: 0, ex: 1100, ey: 0}; rows.push_back(row);
        row.seg = '{sx: -1030, sy: -500, ex: -1010, ey: -520}; rows.push_back(row);
        row.seg = '{sx: 3000, sy: 3000, ex: -3000, ey: -3000}; rows.push_back(row);
        foreach (rows[i])
            send_segment(rows[i].seg, rows[i].typed ? rows[i].res : clip_segment(rows[i].seg));
        idle_input();
        drain();

        // extreme windows: maximum width and height with edges at the coordinate limits
        set_window(32'h0000_7FFF, 32'h0000_8000, 32'h0000_7FFF, 32'h0000_7FFF);
        g = '{sx: 32767, sy: -32768, ex: 32767, ey: 32767};
        send_segment(g, clip_segment(g));
        g = '{sx: -32768, sy: -32768, ex: 32767, ey: 0};
        send_segment(g, clip_segment(g));
        idle_input();
        drain();
        set_window(32'h0000_8000, 32'h0000_8000, 32'h0000_7FFF, 32'h0000_7FFF);
        g = '{sx: -32768, sy: -32768, ex: 32767, ey: 32767};
        send_segment(g, clip_segment(g));
        g = '{sx: 100, sy: -32768, ex: 100, ey: 32767};
        send_segment(g, clip_segment(g));
        idle_input();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_window($urandom, $urandom, $urandom_range(0, 4000), $urandom_range(0, 4000));
                1: set_window(32'd0, 32'd0, 32'd0, 32'd0);
                2: set_window($urandom, $urandom, $urandom, $urandom);
                default: set_window($urandom_range(0, 2000), $urandom_range(0, 2000), 32'd300,
                                    32'd200);
            endcase
            for (k = 0; k < N_RANDOM / 4; k++) begin
                // mostly segments near the window, some anywhere
                mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
                g.sx = rand_coord(mode);
                g.ex = rand_coord(mode);
                g.sy = rand_coord(mode == 0 ? 0 : 2);
                g.ey = rand_coord(mode == 0 ? 0 : 2);
                if ($urandom_range(0, 9) == 0) g.ex = g.sx;
                if ($urandom_range(0, 9) == 0) g.ey = g.sy;
                send_segment(g, clip_segment(g));
                if (k == 100) begin
                    idle_input();
                    while (visible_q.size() != 0) @(posedge aclk);
                end
            end
            idle_input();
            drain();
        end
        stim_done = 1;
    end

    initial begin : finisher
        wait (stim_done);
        if (errors == 0 && visible_q.size() == 0) begin
            $display("tb_line_segment_window_clipper_top: done, clean");
        end else begin
            $display("tb_line_segment_window_clipper_top: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb_line_segment_window_clipper_top: done, errors");
        $finish;
    end

endmodule
